### src/sgrad_pkg.sv
package sgrad_pkg;

	typedef enum logic [3:0] {
		KIND_RESET     = 4'd0,
		KIND_BOLD      = 4'd1,
		KIND_DIM       = 4'd2,
		KIND_ITALIC    = 4'd3,
		KIND_UNDERLINE = 4'd4,
		KIND_BLINK     = 4'd5,
		KIND_INVERSE   = 4'd6,
		KIND_HIDDEN    = 4'd7,
		KIND_STRIKE    = 4'd8,
		KIND_FG        = 4'd9,
		KIND_BG        = 4'd10
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_SEEN  = 2'd1,
		PH_INDEX = 2'd2
	} phase_t;

	localparam logic [7:0] BASIC_LEVEL = 8'd204;
	localparam logic [7:0] BRIGHT_GREY = 8'd128;
	localparam logic [7:0] FULL_LEVEL  = 8'd255;
	localparam logic [7:0] CUBE_STEP   = 8'd51;
	localparam logic [7:0] GREY_STEP   = 8'd10;

	localparam logic [15:0] CODE_EXT_FG   = 16'd38;
	localparam logic [15:0] CODE_EXT_BG   = 16'd48;
	localparam logic [15:0] CODE_EXT_MODE = 16'd5;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct packed {
		kind_t kind;
		logic  enable;
		rgb_t  rgb;
		logic  last;
	} event_t;

	typedef struct packed {
		phase_t phase;
		logic   bg;
	} ext_t;

	typedef struct packed {
		event_t     first;
		event_t     second;
		logic [1:0] count;
		ext_t       nxt;
	} dec_t;

	function automatic event_t mk_event(input kind_t k, input logic en, input rgb_t c,
			input logic l);
		event_t e;
		e.kind = k;
		e.enable = en;
		e.rgb = c;
		e.last = l;
		return e;
	endfunction

	function automatic rgb_t basic_rgb(input logic [2:0] i);
		rgb_t c;
		c.r = i[0] ? BASIC_LEVEL : 8'd0;
		c.g = i[1] ? BASIC_LEVEL : 8'd0;
		c.b = i[2] ? BASIC_LEVEL : 8'd0;
		return c;
	endfunction

	function automatic rgb_t bright_rgb(input logic [2:0] i);
		rgb_t c;
		if (i == 3'd0) begin
			c.r = BRIGHT_GREY;
			c.g = BRIGHT_GREY;
			c.b = BRIGHT_GREY;
		end else begin
			c.r = i[0] ? FULL_LEVEL : 8'd0;
			c.g = i[1] ? FULL_LEVEL : 8'd0;
			c.b = i[2] ? FULL_LEVEL : 8'd0;
		end
		return c;
	endfunction

	// The cube index is split by 36 and then by 6 through reciprocal multiplies
	// that are exact over the cube range.
	function automatic rgb_t palette_rgb(input logic [15:0] code);
		logic [7:0]  idx;
		logic [7:0]  c;
		logic [13:0] prod36;
		logic [2:0]  q36;
		logic [5:0]  rem36;
		logic [10:0] prod6;
		logic [2:0]  q6;
		logic [2:0]  rem6;
		logic [4:0]  grey;
		rgb_t        res;
		idx = (code > 16'd255) ? 8'hFF : code[7:0];
		c = idx - 8'd16;
		prod36 = 14'(c) * 14'd57;
		q36 = prod36[13:11];
		rem36 = 6'(c - 8'(q36) * 8'd36);
		prod6 = 11'(rem36) * 11'd43;
		q6 = prod6[10:8];
		rem6 = 3'(rem36 - 6'(q6) * 6'd6);
		grey = 5'(idx - 8'd232);
		if (idx < 8'd8) begin
			res = basic_rgb(idx[2:0]);
		end else if (idx < 8'd16) begin
			res = bright_rgb(idx[2:0]);
		end else if (idx < 8'd232) begin
			res.r = 8'(q36) * CUBE_STEP;
			res.g = 8'(q6) * CUBE_STEP;
			res.b = 8'(rem6) * CUBE_STEP;
		end else begin
			res.r = 8'(grey) * GREY_STEP;
			res.g = res.r;
			res.b = res.r;
		end
		return res;
	endfunction

endpackage

### src/sgrad_decode.sv
module sgrad_decode (
	input  logic [15:0]       code,
	input  logic              last_param,
	input  sgrad_pkg::ext_t   st,
	output sgrad_pkg::dec_t   dec
);

	sgrad_pkg::event_t plain_first;
	sgrad_pkg::event_t plain_second;
	logic [1:0]        plain_count;
	logic              ext_code;

	always_comb begin
		plain_first = sgrad_pkg::mk_event(sgrad_pkg::KIND_RESET, 1'b0, '0, 1'b1);
		plain_second = plain_first;
		plain_count = 2'd1;
		case (code) inside
			16'd0: begin
				plain_first = sgrad_pkg::mk_event(sgrad_pkg::KIND_RESET, 1'b0, '0, 1'b1);
			end
			[16'd1:16'd5]: begin
				plain_first = sgrad_pkg::mk_event(sgrad_pkg::kind_t'(code[3:0]), 1'b1, '0,
						1'b1);
			end
			[16'd7:16'd9]: begin
				plain_first = sgrad_pkg::mk_event(sgrad_pkg::kind_t'(code[3:0] - 4'd1), 1'b1,
						'0, 1'b1);
			end
			16'd22: begin
				plain_first = sgrad_pkg::mk_event(sgrad_pkg::KIND_BOLD, 1'b0, '0, 1'b0);
				plain_second = sgrad_pkg::mk_event(sgrad_pkg::KIND_DIM, 1'b0, '0, 1'b1);
				plain_count = 2'd2;
			end
			[16'd23:16'd25]: begin
				plain_first = sgrad_pkg::mk_event(sgrad_pkg::kind_t'(code[3:0] - 4'd4), 1'b0,
						'0, 1'b1);
			end
			[16'd27:16'd29]: begin
				plain_first = sgrad_pkg::mk_event(sgrad_pkg::kind_t'(code[3:0] - 4'd5), 1'b0,
						'0, 1'b1);
			end
			[16'd30:16'd37]: begin
				plain_first = sgrad_pkg::mk_event(sgrad_pkg::KIND_FG, 1'b0,
						sgrad_pkg::basic_rgb(code[2:0] - 3'd6), 1'b1);
			end
			16'd39: begin
				plain_first = sgrad_pkg::mk_event(sgrad_pkg::KIND_FG, 1'b0,
						{sgrad_pkg::FULL_LEVEL, sgrad_pkg::FULL_LEVEL, sgrad_pkg::FULL_LEVEL},
						1'b1);
			end
			[16'd40:16'd47]: begin
				plain_first = sgrad_pkg::mk_event(sgrad_pkg::KIND_BG, 1'b0,
						sgrad_pkg::basic_rgb(code[2:0]), 1'b1);
			end
			16'd49: begin
				plain_first = sgrad_pkg::mk_event(sgrad_pkg::KIND_BG, 1'b0, '0, 1'b1);
			end
			[16'd90:16'd97]: begin
				plain_first = sgrad_pkg::mk_event(sgrad_pkg::KIND_FG, 1'b0,
						sgrad_pkg::bright_rgb(code[2:0] - 3'd2), 1'b1);
			end
			[16'd100:16'd107]: begin
				plain_first = sgrad_pkg::mk_event(sgrad_pkg::KIND_BG, 1'b0,
						sgrad_pkg::bright_rgb(code[2:0] - 3'd4), 1'b1);
			end
			default: begin
				plain_count = 2'd0;
			end
		endcase
	end

	assign ext_code = (code == sgrad_pkg::CODE_EXT_FG) || (code == sgrad_pkg::CODE_EXT_BG);

	always_comb begin
		dec.first = plain_first;
		dec.second = plain_second;
		dec.count = 2'd0;
		dec.nxt.phase = sgrad_pkg::PH_IDLE;
		dec.nxt.bg = st.bg;
		if (st.phase == sgrad_pkg::PH_INDEX) begin
			dec.first = sgrad_pkg::mk_event(st.bg ? sgrad_pkg::KIND_BG : sgrad_pkg::KIND_FG,
					1'b0, sgrad_pkg::palette_rgb(code), 1'b1);
			dec.count = 2'd1;
		end else if (st.phase == sgrad_pkg::PH_SEEN && code == sgrad_pkg::CODE_EXT_MODE &&
				!last_param) begin
			dec.nxt.phase = sgrad_pkg::PH_INDEX;
		end else if (ext_code && !last_param) begin
			dec.nxt.phase = sgrad_pkg::PH_SEEN;
			dec.nxt.bg = (code == sgrad_pkg::CODE_EXT_BG);
		end else if (!ext_code) begin
			dec.count = plain_count;
		end
		if (last_param) begin
			dec.nxt.phase = sgrad_pkg::PH_IDLE;
		end
	end

endmodule

### src/sgr_attribute_decoder.sv
// Select-graphic-rendition parameter decoder.
// The param channel takes one numeric parameter per word (code, last_param);
// the event channel gives attribute and color words (event_kind, enable,
// red, green, blue, last_of_run). Both channels use valid/ready.
// A parameter is held in an input register while it is decoded, and its
// events are loaded into a two-slot result register, from which the first
// event of a parameter is presented.
// One parameter is accepted every cycle while the event side keeps up. Code 22
// gives two events and holds the result register until both are taken, so the
// next parameter waits behind them. Parameters that give no event pass through
// without using an output cycle.
// The 38;5;n and 48;5;n color pairs are tracked across parameters, and the
// final parameter of a sequence clears that tracking.
// Reset clears the pipeline valid flags and the tracking state.
// When the receiver stalls, the result register holds its word, the input
// register fills behind it, and param_ready then drops.
module sgr_attribute_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        param_valid,
	output logic        param_ready,
	input  logic [15:0] code,
	input  logic        last_param,
	output logic        event_valid,
	input  logic        event_ready,
	output logic [3:0]  event_kind,
	output logic        enable,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        last_of_run
);

	logic              valid_s1;
	logic [15:0]       code_s1;
	logic              last_s1;
	logic [1:0]        cnt_s2;
	sgrad_pkg::event_t first_s2;
	sgrad_pkg::event_t second_s2;
	sgrad_pkg::ext_t   ext_q;
	sgrad_pkg::dec_t   dec;
	sgrad_pkg::event_t cur;
	logic              s2_free;
	logic              s1_adv;

	sgrad_decode u_decode (
		.code       (code_s1),
		.last_param (last_s1),
		.st         (ext_q),
		.dec        (dec)
	);

	assign s2_free = (cnt_s2 == 2'd0) || (cnt_s2 == 2'd1 && event_ready);
	assign s1_adv = valid_s1 && s2_free;
	assign param_ready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_s2 <= 2'd0;
			ext_q.phase <= sgrad_pkg::PH_IDLE;
			ext_q.bg <= 1'b0;
		end else begin
			if (param_ready) begin
				valid_s1 <= param_valid;
			end
			if (s1_adv) begin
				cnt_s2 <= dec.count;
				ext_q <= dec.nxt;
			end else if (event_valid && event_ready) begin
				cnt_s2 <= cnt_s2 - 2'd1;
			end
		end
	end

	// A single event goes to the second slot, so the slot shown depends only on the count.
	always_ff @(posedge clk) begin
		if (param_valid && param_ready) begin
			code_s1 <= code;
			last_s1 <= last_param;
		end
		if (s1_adv) begin
			first_s2 <= dec.first;
			second_s2 <= (dec.count == 2'd1) ? dec.first : dec.second;
		end
	end

	assign cur = (cnt_s2 == 2'd2) ? first_s2 : second_s2;

	assign event_valid = (cnt_s2 != 2'd0);
	assign event_kind = cur.kind;
	assign enable = cur.enable;
	assign red = cur.rgb.r;
	assign green = cur.rgb.g;
	assign blue = cur.rgb.b;
	assign last_of_run = cur.last;

`ifndef ASSERT_OFF
	a_pair_first: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_s2 == 2'd2) |-> (event_kind == sgrad_pkg::KIND_BOLD && !last_of_run))
		else $error("first word of a pair is not bold off");

	a_pair_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_s2 == 2'd2 && event_ready) |=> (cnt_s2 == 2'd1 &&
		event_kind == sgrad_pkg::KIND_DIM && last_of_run))
		else $error("second word of a pair not presented");

	a_seq_end: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && last_s1) |=> (ext_q.phase == sgrad_pkg::PH_IDLE))
		else $error("color tracking survives end of sequence");
`endif

endmodule

### test/tb_sgr_attribute_decoder.sv
module tb_sgr_attribute_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import sgrad_pkg::*;

	localparam logic [15:0] CODE_RESET       = 16'd0;
	localparam logic [15:0] CODE_NO_ATTR     = 16'd6;
	localparam logic [15:0] CODE_ATTR_LAST   = 16'd9;
	localparam logic [15:0] CODE_OFF_OFFSET  = 16'd20;
	localparam logic [15:0] CODE_BOLD_DIM    = 16'd22;
	localparam logic [15:0] CODE_OFF_FIRST   = 16'd23;
	localparam logic [15:0] CODE_NO_OFF      = 16'd26;
	localparam logic [15:0] CODE_OFF_LAST    = 16'd29;
	localparam logic [15:0] CODE_FG_BASE     = 16'd30;
	localparam logic [15:0] CODE_FG_DEFAULT  = 16'd39;
	localparam logic [15:0] CODE_BG_BASE     = 16'd40;
	localparam logic [15:0] CODE_BG_DEFAULT  = 16'd49;
	localparam logic [15:0] CODE_FG_BRIGHT   = 16'd90;
	localparam logic [15:0] CODE_BG_BRIGHT   = 16'd100;
	localparam logic [15:0] CODE_HIDDEN      = 16'd8;
	localparam logic [15:0] CODE_MAX         = 16'hFFFF;
	localparam int          ITEM_TARGET      = 1900;
	localparam int          DRAIN_EVERY      = 500;

	typedef struct {
		logic [15:0] code;
		logic        last;
		bit          drain;
	} param_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        param_valid = 1'b0;
	logic        param_ready;
	logic [15:0] code = 16'd0;
	logic        last_param = 1'b0;
	logic        event_valid;
	logic        event_ready = 1'b0;
	logic [3:0]  event_kind;
	logic        enable;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic        last_of_run;

	param_item_t pending_params[$];
	event_t      expected_events[$];
	phase_t      ext_phase = PH_IDLE;
	logic        ext_bg = 1'b0;
	int          mismatches = 0;
	int          word_count = 0;
	int          stim_count = 0;
	int          gap_left = 0;
	int          burst_left = 0;
	bit          waiting_drain = 1'b0;
	int          ready_left = 0;
	bit          ready_hold = 1'b0;

	sgr_attribute_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.param_valid(param_valid),
		.param_ready(param_ready),
		.code(code),
		.last_param(last_param),
		.event_valid(event_valid),
		.event_ready(event_ready),
		.event_kind(event_kind),
		.enable(enable),
		.red(red),
		.green(green),
		.blue(blue),
		.last_of_run(last_of_run)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 50) begin
			$display("mismatch at %0t: %s", $realtime, msg);
		end
	endtask

	function automatic kind_t attr_kind(input logic [15:0] c);
		case (c)
			16'd1: return KIND_BOLD;
			16'd2: return KIND_DIM;
			16'd3: return KIND_ITALIC;
			16'd4: return KIND_UNDERLINE;
			16'd5: return KIND_BLINK;
			16'd7: return KIND_INVERSE;
			16'd8: return KIND_HIDDEN;
			default: return KIND_STRIKE;
		endcase
	endfunction

	function automatic rgb_t basic_color(input logic [2:0] i);
		rgb_t c;
		c.r = i[0] ? BASIC_LEVEL : 8'd0;
		c.g = i[1] ? BASIC_LEVEL : 8'd0;
		c.b = i[2] ? BASIC_LEVEL : 8'd0;
		return c;
	endfunction

	function automatic rgb_t bright_color(input logic [2:0] i);
		rgb_t c;
		if (i == 3'd0) begin
			c = '{BRIGHT_GREY, BRIGHT_GREY, BRIGHT_GREY};
		end else begin
			c.r = i[0] ? FULL_LEVEL : 8'd0;
			c.g = i[1] ? FULL_LEVEL : 8'd0;
			c.b = i[2] ? FULL_LEVEL : 8'd0;
		end
		return c;
	endfunction

	function automatic rgb_t palette_color(input logic [15:0] index);
		int   n;
		int   cube;
		rgb_t c;
		n = (index > 16'd255) ? 255 : int'(index);
		if (n < 8) begin
			c = basic_color(3'(n));
		end else if (n < 16) begin
			c = bright_color(3'(n - 8));
		end else if (n < 232) begin
			cube = n - 16;
			c.r = 8'((cube / 36) * int'(CUBE_STEP));
			c.g = 8'(((cube % 36) / 6) * int'(CUBE_STEP));
			c.b = 8'((cube % 6) * int'(CUBE_STEP));
		end else begin
			c.r = 8'((n - 232) * int'(GREY_STEP));
			c.g = c.r;
			c.b = c.r;
		end
		return c;
	endfunction

	task automatic push_word(input kind_t k, input logic en, input rgb_t c, input logic l);
		event_t w;
		w.kind = k;
		w.enable = en;
		w.rgb = c;
		w.last = l;
		expected_events.insert(expected_events.size(), w);
	endtask

	task automatic predict_events(input logic [15:0] c, input logic fin);
		if (ext_phase == PH_INDEX) begin
			push_word(ext_bg ? KIND_BG : KIND_FG, 1'b0, palette_color(c), 1'b1);
			ext_phase = PH_IDLE;
		end else if (ext_phase == PH_SEEN && c == CODE_EXT_MODE && !fin) begin
			ext_phase = PH_INDEX;
		end else begin
			ext_phase = PH_IDLE;
			if (c == CODE_EXT_FG || c == CODE_EXT_BG) begin
				if (!fin) begin
					ext_phase = PH_SEEN;
					ext_bg = (c == CODE_EXT_BG);
				end
			end else if (c == CODE_RESET) begin
				push_word(KIND_RESET, 1'b0, '0, 1'b1);
			end else if (c <= CODE_ATTR_LAST && c != CODE_NO_ATTR) begin
				push_word(attr_kind(c), 1'b1, '0, 1'b1);
			end else if (c == CODE_BOLD_DIM) begin
				push_word(KIND_BOLD, 1'b0, '0, 1'b0);
				push_word(KIND_DIM, 1'b0, '0, 1'b1);
			end else if (c >= CODE_OFF_FIRST && c <= CODE_OFF_LAST && c != CODE_NO_OFF) begin
				push_word(attr_kind(c - CODE_OFF_OFFSET), 1'b0, '0, 1'b1);
			end else if (c >= CODE_FG_BASE && c < CODE_FG_BASE + 16'd8) begin
				push_word(KIND_FG, 1'b0, basic_color(3'(c - CODE_FG_BASE)), 1'b1);
			end else if (c >= CODE_BG_BASE && c < CODE_BG_BASE + 16'd8) begin
				push_word(KIND_BG, 1'b0, basic_color(3'(c - CODE_BG_BASE)), 1'b1);
			end else if (c == CODE_FG_DEFAULT) begin
				push_word(KIND_FG, 1'b0, '{FULL_LEVEL, FULL_LEVEL, FULL_LEVEL}, 1'b1);
			end else if (c == CODE_BG_DEFAULT) begin
				push_word(KIND_BG, 1'b0, '0, 1'b1);
			end else if (c >= CODE_FG_BRIGHT && c < CODE_FG_BRIGHT + 16'd8) begin
				push_word(KIND_FG, 1'b0, bright_color(3'(c - CODE_FG_BRIGHT)), 1'b1);
			end else if (c >= CODE_BG_BRIGHT && c < CODE_BG_BRIGHT + 16'd8) begin
				push_word(KIND_BG, 1'b0, bright_color(3'(c - CODE_BG_BRIGHT)), 1'b1);
			end
		end
		if (fin) begin
			ext_phase = PH_IDLE;
		end
	endtask

	task automatic push_param(input logic [15:0] c, input logic fin);
		param_item_t item;
		item.code = c;
		item.last = fin;
		item.drain = 1'b0;
		pending_params.insert(pending_params.size(), item);
		stim_count++;
	endtask

	task automatic push_drain();
		param_item_t item;
		item.code = '0;
		item.last = 1'b0;
		item.drain = 1'b1;
		pending_params.insert(pending_params.size(), item);
	endtask

	always @(posedge clk) begin : drive_params
		param_item_t item;
		int          r;
		if (arst_n) begin
			if (param_valid && param_ready) begin
				predict_events(code, last_param);
			end
			if (param_valid && !param_ready) begin
				param_valid <= 1'b1;
			end else if (waiting_drain) begin
				param_valid <= 1'b0;
				if (expected_events.size() == 0) begin
					waiting_drain = 1'b0;
				end
			end else if (gap_left != 0) begin
				param_valid <= 1'b0;
				gap_left--;
			end else if (pending_params.size() != 0) begin
				item = pending_params.pop_front();
				if (item.drain) begin
					waiting_drain = 1'b1;
					param_valid <= 1'b0;
				end else begin
					code <= item.code;
					last_param <= item.last;
					param_valid <= 1'b1;
					r = $urandom_range(0, 99);
					if (burst_left != 0) begin
						burst_left--;
						gap_left = 0;
					end else if (r < 3) begin
						burst_left = $urandom_range(20, 80);
						gap_left = 0;
					end else if (r < 65) begin
						gap_left = 0;
					end else if (r < 95) begin
						gap_left = $urandom_range(1, 3);
					end else begin
						gap_left = $urandom_range(8, 30);
					end
				end
			end else begin
				param_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_events
		event_t want;
		int     r;
		if (arst_n) begin
			if (event_valid && event_ready) begin
				word_count++;
				if (expected_events.size() == 0) begin
					report_mismatch({$sformatf("word %0d not expected: ", word_count),
						$sformatf("kind=%0d en=%0b rgb=%02h%02h%02h last=%0b",
						event_kind, enable, red, green, blue, last_of_run)});
				end else begin
					want = expected_events.pop_front();
					if (event_kind !== want.kind || enable !== want.enable ||
							red !== want.rgb.r || green !== want.rgb.g ||
							blue !== want.rgb.b || last_of_run !== want.last) begin
						report_mismatch({
							$sformatf("word %0d: got kind=%0d en=%0b rgb=%02h%02h%02h last=%0b",
							word_count, event_kind, enable, red, green, blue, last_of_run),
							$sformatf(", want kind=%0d en=%0b rgb=%02h%02h%02h last=%0b",
							want.kind, want.enable, want.rgb.r, want.rgb.g, want.rgb.b,
							want.last)});
					end
				end
			end
			if (ready_left != 0) begin
				ready_left--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 50) begin
					ready_hold = 1'b1;
					ready_left = $urandom_range(1, 40);
				end else if (r < 92) begin
					ready_hold = 1'b0;
					ready_left = $urandom_range(1, 3);
				end else begin
					ready_hold = 1'b0;
					ready_left = $urandom_range(8, 30);
				end
			end
			event_ready <= ready_hold;
		end
	end

	initial begin : stimulus
		int          seq_len;
		int          pick;
		int          next_drain;
		logic        fin;
		logic [15:0] c;

		// Directed words: edge codes of several code groups, then the extended color cases.
		push_param(CODE_RESET, 1'b0);
		push_param(16'd1, 1'b0);
		push_param(CODE_NO_ATTR, 1'b0);
		push_param(CODE_ATTR_LAST, 1'b0);
		push_param(CODE_BOLD_DIM, 1'b0);
		push_param(CODE_NO_OFF, 1'b0);
		push_param(CODE_OFF_LAST, 1'b0);
		push_param(CODE_FG_BASE, 1'b0);
		push_param(16'd37, 1'b0);
		push_param(CODE_FG_DEFAULT, 1'b0);
		push_param(CODE_BG_DEFAULT, 1'b0);
		push_param(CODE_FG_BRIGHT, 1'b0);
		push_param(16'd107, 1'b1);
		push_param(CODE_EXT_FG, 1'b0);
		push_param(CODE_EXT_MODE, 1'b0);
		push_param(16'd0, 1'b0);
		push_param(CODE_EXT_BG, 1'b0);
		push_param(CODE_EXT_MODE, 1'b0);
		push_param(CODE_MAX, 1'b1);
		push_param(CODE_EXT_FG, 1'b1);
		push_param(CODE_EXT_BG, 1'b0);
		push_param(CODE_HIDDEN - 16'd1, 1'b0);
		push_param(CODE_EXT_FG, 1'b0);
		push_param(CODE_EXT_MODE, 1'b1);
		push_param(CODE_EXT_BG, 1'b0);
		push_param(CODE_EXT_MODE, 1'b0);
		push_param(16'd231, 1'b0);
		push_param(16'd232, 1'b1);
		push_drain();

		next_drain = DRAIN_EVERY;
		while (stim_count < ITEM_TARGET) begin
			seq_len = $urandom_range(1, 6);
			for (int k = 0; k < seq_len; k++) begin
				fin = (k == seq_len - 1);
				pick = $urandom_range(0, 99);
				if (pick < 30) begin
					push_param($urandom_range(0, 1) ? CODE_EXT_BG : CODE_EXT_FG, 1'b0);
					push_param(CODE_EXT_MODE, 1'b0);
					if ($urandom_range(0, 9) == 0) begin
						push_param(16'($urandom_range(256, 65535)), fin);
					end else begin
						push_param(16'($urandom_range(0, 255)), fin);
					end
				end else if (pick < 80) begin
					case ($urandom_range(0, 6))
						0: c = 16'($urandom_range(0, 9));
						1: c = 16'($urandom_range(22, 29));
						2: c = 16'($urandom_range(30, 39));
						3: c = 16'($urandom_range(40, 49));
						4: c = 16'($urandom_range(90, 97));
						5: c = 16'($urandom_range(100, 107));
						default: c = 16'($urandom_range(0, 127));
					endcase
					push_param(c, fin);
				end else if (pick < 90) begin
					push_param(16'($urandom), 1'($urandom));
				end else begin
					push_param($urandom_range(0, 1) ? CODE_EXT_BG : CODE_EXT_FG, 1'b0);
					if ($urandom_range(0, 1)) begin
						push_param(CODE_EXT_MODE, 1'b1);
					end else begin
						push_param(16'($urandom_range(0, 107)), fin);
					end
				end
			end
			if (stim_count >= next_drain) begin
				push_drain();
				next_drain += DRAIN_EVERY;
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (pending_params.size() != 0 || param_valid || waiting_drain ||
				expected_events.size() != 0) begin
			@(negedge clk);
		end
		repeat (20) @(negedge clk);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
